### src/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/pic2cm_pkg.sv
// Types and constants shared by the icon cursor mask block.
`timescale 1ns / 1ps
`default_nettype none

package pic2cm_pkg;

   localparam int PIXELS_PER_BEAT = 8;
   localparam int PIXEL_W         = 8;
   localparam int DEST_ROW_W      = 5;
   localparam int DEST_BYTE_W     = 2;
   localparam int HOT_X_W         = 6;
   localparam int HOT_Y_W         = 5;
   localparam int HOT_IDX_W       = 3;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;

   // Register reset values
   localparam logic [7:0] BACKGROUND_COLOR_RST = 8'd0;
   localparam logic [7:0] WHITE_START_RST      = 8'd240;
   localparam logic [8:0] STANDARD_COLORS_RST  = 9'd256;
   localparam logic [7:0] YELLOW_CENTER_RST    = 8'd96;
   localparam logic [7:0] BLUE_CENTER_RST      = 8'd160;
   localparam logic [7:0] RESERVED_COLORS_RST  = 8'd16;

   // Register word index (byte address / 4)
   typedef enum logic [2:0] {
      REG_BACKGROUND_COLOR = 3'd0,
      REG_WHITE_START      = 3'd1,
      REG_STANDARD_COLORS  = 3'd2,
      REG_YELLOW_CENTER    = 3'd3,
      REG_BLUE_CENTER      = 3'd4,
      REG_RESERVED_COLORS  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [7:0] pixel_0;
      logic [7:0] pixel_1;
      logic [7:0] pixel_2;
      logic [7:0] pixel_3;
      logic [7:0] pixel_4;
      logic [7:0] pixel_5;
      logic [7:0] pixel_6;
      logic [7:0] pixel_7;
   } req_type;

   typedef struct packed {
      logic [7:0]             and_mask_byte;
      logic [7:0]             xor_mask_byte;
      logic [DEST_ROW_W-1:0]  dest_row;
      logic [DEST_BYTE_W-1:0] dest_byte;
      logic [HOT_X_W-1:0]     hot_x;
      logic [HOT_Y_W-1:0]     hot_y;
      logic                   image_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0] background_color;
      logic [7:0] white_start;
      logic [8:0] standard_colors;
      logic [7:0] yellow_center;
      logic [7:0] blue_center;
      logic [7:0] reserved_colors;
   } cfg_type;

endpackage

`default_nettype wire

### src/pic2cm_classify.sv
// Per-pixel palette classification of one eight-pixel beat into mask bits.
`timescale 1ns / 1ps
`default_nettype none

module pic2cm_classify
   import pic2cm_pkg::*;
#(
   parameter int LEVEL_STEP = 16
) (
   input  cfg_type                cfg,
   input  req_type                pixels,
   output logic [7:0]             and_mask,
   output logic [7:0]             xor_mask,
   output logic                   hot_hit,
   output logic [HOT_IDX_W-1:0]   hot_idx
);

   localparam logic signed [10:0] LEV = 11'(LEVEL_STEP);

   // Stripe pattern of the shaded levels: low half of each level step is lit
   logic [255:0] stripe_lut;

   for (genvar g = 0; g < 256; g++) begin : g_stripe
      assign stripe_lut[g] = ((g % LEVEL_STEP) < (LEVEL_STEP / 2));
   end

   // Thresholds, shared by all eight pixels
   logic signed [10:0] white_limit;
   logic signed [10:0] hot_limit;
   logic signed [10:0] invert_limit;
   logic signed [10:0] blue_limit;

   assign white_limit  = $signed({2'b00, cfg.standard_colors}) - LEV;
   assign hot_limit    = $signed({3'b000, cfg.yellow_center}) - LEV;
   assign invert_limit = $signed({3'b000, cfg.yellow_center}) + LEV;
   assign blue_limit   = $signed({3'b000, cfg.blue_center}) - LEV;

   logic [7:0] pix [PIXELS_PER_BEAT];

   assign pix[0] = pixels.pixel_0;
   assign pix[1] = pixels.pixel_1;
   assign pix[2] = pixels.pixel_2;
   assign pix[3] = pixels.pixel_3;
   assign pix[4] = pixels.pixel_4;
   assign pix[5] = pixels.pixel_5;
   assign pix[6] = pixels.pixel_6;
   assign pix[7] = pixels.pixel_7;

   // Classify each pixel; the last hot pixel in the beat wins
   always_comb begin
      logic signed [10:0] cs;
      logic [8:0]         diff;
      logic               stripe;
      logic               hot;
      and_mask = '1;
      xor_mask = '0;
      hot_hit  = 1'b0;
      hot_idx  = '0;
      for (int p = 0; p < PIXELS_PER_BEAT; p++) begin
         cs     = $signed({3'b000, pix[p]});
         diff   = {1'b0, pix[p]} - {1'b0, cfg.reserved_colors};
         stripe = (pix[p] < cfg.reserved_colors) ? 1'b1 : stripe_lut[diff[7:0]];
         hot    = 1'b0;
         if (pix[p] == cfg.background_color) begin
            and_mask[7-p] = 1'b1;
         end else if (pix[p] >= cfg.white_start) begin
            and_mask[7-p] = 1'b0;
            xor_mask[7-p] = (cs < white_limit);
         end else begin
            hot = (cs >= hot_limit);
            if (cs <= invert_limit) begin
               xor_mask[7-p] = 1'b1;
            end else if (cs < blue_limit) begin
               and_mask[7-p] = 1'b0;
               xor_mask[7-p] = stripe;
            end
         end
         if (hot) begin
            hot_hit = 1'b1;
            hot_idx = HOT_IDX_W'(p);
         end
      end
   end

endmodule

`default_nettype wire

### src/palette_icon_to_cursor_masks.sv
// Top level: palette icon beats in, cursor AND/XOR mask bytes and hot spot out.
//
//   channel | direction | handshake         | beat
//   req     | in        | req_valid/stall   | eight pixel palette indices
//   rsp     | out       | rsp_valid/stall   | mask bytes, position, hot spot
//   csr     | in/out    | APB psel/penable  | six 32-bit registers at 4*i
//
// One beat per clock cycle sustained while rsp is not stalled; an accepted beat
// is loaded into the input register, then into the result register, which
// offers it on rsp.
// Reset is synchronous; there is no clear pass.
// A stall on rsp holds the result register; req stalls only when both the
// input and result registers are full.
`timescale 1ns / 1ps
`default_nettype none

module palette_icon_to_cursor_masks
   import pic2cm_pkg::*;
#(
   parameter int ICON_SIDE  = 32,
   parameter int LEVEL_STEP = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int BYTES_PER_ROW = ICON_SIDE / 8;
   localparam int BW            = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
   localparam int RW            = $clog2(ICON_SIDE);
   localparam int CW            = BW + HOT_IDX_W + 1;
   localparam logic [BW-1:0]      LAST_BYTE = BW'(BYTES_PER_ROW - 1);
   localparam logic [RW-1:0]      TOP_ROW   = RW'(ICON_SIDE - 1);
   localparam logic [HOT_X_W-1:0] CENTER_X  = HOT_X_W'(ICON_SIDE / 2);
   localparam logic [HOT_Y_W-1:0] CENTER_Y  = HOT_Y_W'(ICON_SIDE / 2);

   // Registers
   cfg_type              cfg_ff, cfg_in;
   logic                 in_valid_ff, in_valid_in;
   req_type              in_data_ff, in_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [BW-1:0]        byte_idx_ff, byte_idx_in;
   logic [RW-1:0]        dest_row_ff, dest_row_in;
   logic [HOT_X_W-1:0]   hot_x_ff, hot_x_in;
   logic [HOT_Y_W-1:0]   hot_y_ff, hot_y_in;

   // Classification of the beat held in the input register
   logic [7:0]           and_mask;
   logic [7:0]           xor_mask;
   logic                 hot_hit;
   logic [HOT_IDX_W-1:0] hot_idx;

   pic2cm_classify #(
      .LEVEL_STEP(LEVEL_STEP)
   ) u_classify (
      .cfg      (cfg_ff),
      .pixels   (in_data_ff),
      .and_mask (and_mask),
      .xor_mask (xor_mask),
      .hot_hit  (hot_hit),
      .hot_idx  (hot_idx)
   );

   // Handshake: each stage loads when its downstream side is free
   logic out_free;
   logic in_free;
   logic advance;
   logic csr_write;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_free   = !in_valid_ff || out_free;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = !in_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   // Register file write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index_type'(paddr[4:2]))
            REG_BACKGROUND_COLOR: cfg_in.background_color = pwdata[7:0];
            REG_WHITE_START:      cfg_in.white_start      = pwdata[7:0];
            REG_STANDARD_COLORS:  cfg_in.standard_colors  = pwdata[8:0];
            REG_YELLOW_CENTER:    cfg_in.yellow_center    = pwdata[7:0];
            REG_BLUE_CENTER:      cfg_in.blue_center      = pwdata[7:0];
            REG_RESERVED_COLORS:  cfg_in.reserved_colors  = pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register file read back
   always_comb begin
      case (reg_index_type'(paddr[4:2]))
         REG_BACKGROUND_COLOR: prdata = CSR_DATA_W'(cfg_ff.background_color);
         REG_WHITE_START:      prdata = CSR_DATA_W'(cfg_ff.white_start);
         REG_STANDARD_COLORS:  prdata = CSR_DATA_W'(cfg_ff.standard_colors);
         REG_YELLOW_CENTER:    prdata = CSR_DATA_W'(cfg_ff.yellow_center);
         REG_BLUE_CENTER:      prdata = CSR_DATA_W'(cfg_ff.blue_center);
         REG_RESERVED_COLORS:  prdata = CSR_DATA_W'(cfg_ff.reserved_colors);
         default:              prdata = '0;
      endcase
   end

   // Pipeline advance, position counters and hot spot tracking
   always_comb begin
      logic [HOT_X_W-1:0] hot_x_now;
      logic [HOT_Y_W-1:0] hot_y_now;
      logic               done;
      logic [CW-1:0]      column;

      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      byte_idx_in  = byte_idx_ff;
      dest_row_in  = dest_row_ff;
      hot_x_in     = hot_x_ff;
      hot_y_in     = hot_y_ff;

      column    = {1'b0, byte_idx_ff, hot_idx} + CW'(1);
      hot_x_now = hot_hit ? HOT_X_W'(column) : hot_x_ff;
      hot_y_now = hot_hit ? HOT_Y_W'(dest_row_ff) : hot_y_ff;
      done      = (dest_row_ff == '0) && (byte_idx_ff == LAST_BYTE);

      // Take a new beat into the input register
      if (in_free) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_data_in = req_data;
         end
      end

      // Move the classified beat into the result register
      if (out_free) begin
         rsp_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_data_in.and_mask_byte = and_mask;
         rsp_data_in.xor_mask_byte = xor_mask;
         rsp_data_in.dest_row      = DEST_ROW_W'(dest_row_ff);
         rsp_data_in.dest_byte     = DEST_BYTE_W'(byte_idx_ff);
         rsp_data_in.hot_x         = hot_x_now;
         rsp_data_in.hot_y         = hot_y_now;
         rsp_data_in.image_done    = done;

         if (byte_idx_ff == LAST_BYTE) begin
            byte_idx_in = '0;
            dest_row_in = done ? TOP_ROW : dest_row_ff - RW'(1);
         end else begin
            byte_idx_in = byte_idx_ff + BW'(1);
         end

         // Recenter the hot spot after the last beat of an image
         hot_x_in = done ? CENTER_X : hot_x_now;
         hot_y_in = done ? CENTER_Y : hot_y_now;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.background_color <= BACKGROUND_COLOR_RST;
         cfg_ff.white_start      <= WHITE_START_RST;
         cfg_ff.standard_colors  <= STANDARD_COLORS_RST;
         cfg_ff.yellow_center    <= YELLOW_CENTER_RST;
         cfg_ff.blue_center      <= BLUE_CENTER_RST;
         cfg_ff.reserved_colors  <= RESERVED_COLORS_RST;
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         byte_idx_ff             <= '0;
         dest_row_ff             <= TOP_ROW;
         hot_x_ff                <= CENTER_X;
         hot_y_ff                <= CENTER_Y;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         byte_idx_ff  <= byte_idx_in;
         dest_row_ff  <= dest_row_in;
         hot_x_ff     <= hot_x_in;
         hot_y_ff     <= hot_y_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### src/pic2cm_checker.sv
// Port-level checks of the icon cursor mask block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pic2cm_checker
   import pic2cm_pkg::*;
#(
   parameter int ICON_SIDE = 32
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   localparam logic [DEST_BYTE_W-1:0] LAST_BYTE = DEST_BYTE_W'(ICON_SIDE / 8 - 1);

   // A stalled result beat stays offered and unchanged
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid,
                "rsp beat dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data),
                "rsp beat changed while stalled")

   // The last beat of an image is the last byte of destination row zero
   `ASSERT_SAME(a_done_pos, clock, reset, rsp_valid && rsp_data.image_done,
                (rsp_data.dest_row == '0) && (rsp_data.dest_byte == LAST_BYTE),
                "image_done away from the final mask byte")

   // Reset empties the result register
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid,
                "rsp valid right after reset")

endmodule

bind palette_icon_to_cursor_masks pic2cm_checker #(
   .ICON_SIDE(ICON_SIDE)
) u_pic2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### tb/palette_icon_to_cursor_masks_tb.sv
// Self-checking testbench for the palette icon to cursor mask block.
`timescale 1ns / 1ps

module palette_icon_to_cursor_masks_tb;
   import pic2cm_pkg::*;

   localparam int ICON_SIDE      = 32;
   localparam int LEVEL_STEP     = 16;
   localparam int BYTES_PER_ROW  = ICON_SIDE / 8;
   localparam int BEATS_PER_ICON = BYTES_PER_ROW * ICON_SIDE;
   localparam int RANDOM_BEATS   = 90;
   localparam int LONG_HOLD      = 60;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 10;

   // Mask predictor and queue of expected mask beats
   class mask_scoreboard;
      cfg_type     cfg;
      int          group_pos;
      int          hot_col;
      int          hot_row;
      rsp_type     expected_masks[$];
      int unsigned mismatches;

      function new();
         cfg.background_color = BACKGROUND_COLOR_RST;
         cfg.white_start      = WHITE_START_RST;
         cfg.standard_colors  = STANDARD_COLORS_RST;
         cfg.yellow_center    = YELLOW_CENTER_RST;
         cfg.blue_center      = BLUE_CENTER_RST;
         cfg.reserved_colors  = RESERVED_COLORS_RST;
         group_pos  = 0;
         hot_col    = ICON_SIDE / 2;
         hot_row    = ICON_SIDE / 2;
         mismatches = 0;
      endfunction

      function void write_reg(int idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_BACKGROUND_COLOR: cfg.background_color = value[7:0];
            REG_WHITE_START:      cfg.white_start      = value[7:0];
            REG_STANDARD_COLORS:  cfg.standard_colors  = value[8:0];
            REG_YELLOW_CENTER:    cfg.yellow_center    = value[7:0];
            REG_BLUE_CENTER:      cfg.blue_center      = value[7:0];
            REG_RESERVED_COLORS:  cfg.reserved_colors  = value[7:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] read_reg(int idx);
         case (idx)
            REG_BACKGROUND_COLOR: return CSR_DATA_W'(cfg.background_color);
            REG_WHITE_START:      return CSR_DATA_W'(cfg.white_start);
            REG_STANDARD_COLORS:  return CSR_DATA_W'(cfg.standard_colors);
            REG_YELLOW_CENTER:    return CSR_DATA_W'(cfg.yellow_center);
            REG_BLUE_CENTER:      return CSR_DATA_W'(cfg.blue_center);
            default:              return CSR_DATA_W'(cfg.reserved_colors);
         endcase
      endfunction

      // Classify eight pixels, build both mask bytes and advance the hot spot
      function rsp_type compute_masks(req_type beat);
         rsp_type    r;
         logic [7:0] pix [8];
         logic [7:0] and_m;
         logic [7:0] xor_m;
         int         c;
         int         byte_idx;
         int         dest_row;
         pix = '{beat.pixel_0, beat.pixel_1, beat.pixel_2, beat.pixel_3,
                 beat.pixel_4, beat.pixel_5, beat.pixel_6, beat.pixel_7};
         byte_idx = group_pos % BYTES_PER_ROW;
         dest_row = ICON_SIDE - 1 - group_pos / BYTES_PER_ROW;
         and_m = 8'hff;
         xor_m = 8'h00;
         for (int p = 0; p < 8; p++) begin
            c = int'(pix[p]);
            if (c == int'(cfg.background_color)) continue;
            if (c >= int'(cfg.white_start)) begin
               and_m[7-p] = 1'b0;
               if (c < int'(cfg.standard_colors) - LEVEL_STEP) xor_m[7-p] = 1'b1;
               continue;
            end
            if (c >= int'(cfg.yellow_center) - LEVEL_STEP) begin
               hot_col = byte_idx * 8 + p + 1;
               hot_row = dest_row;
            end
            if (c <= int'(cfg.yellow_center) + LEVEL_STEP) begin
               xor_m[7-p] = 1'b1;
            end else if (c < int'(cfg.blue_center) - LEVEL_STEP) begin
               and_m[7-p] = 1'b0;
               // truncated remainder: pixels below the level offset go negative
               if (((c - int'(cfg.reserved_colors)) % LEVEL_STEP) < LEVEL_STEP / 2)
                  xor_m[7-p] = 1'b1;
            end
         end
         r.and_mask_byte = and_m;
         r.xor_mask_byte = xor_m;
         r.dest_row      = DEST_ROW_W'(dest_row);
         r.dest_byte     = DEST_BYTE_W'(byte_idx);
         r.hot_x         = HOT_X_W'(hot_col);
         r.hot_y         = HOT_Y_W'(hot_row);
         r.image_done    = (group_pos + 1 >= BEATS_PER_ICON);
         // wrap at the icon boundary and recenter the hot spot
         group_pos = group_pos + 1;
         if (r.image_done) begin
            group_pos = 0;
            hot_col   = ICON_SIDE / 2;
            hot_row   = ICON_SIDE / 2;
         end
         return r;
      endfunction

      function void complain(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
      endfunction

      function string describe(rsp_type r);
         return $sformatf("and=%02h xor=%02h row=%0d byte=%0d hot=(%0d,%0d) done=%0b",
                          r.and_mask_byte, r.xor_mask_byte, r.dest_row, r.dest_byte,
                          r.hot_x, r.hot_y, r.image_done);
      endfunction

      function void note_pixels(req_type beat);
         expected_masks.push_back(compute_masks(beat));
      endfunction

      function void check_masks(rsp_type got);
         rsp_type want;
         if (expected_masks.size() == 0) begin
            complain({"unexpected mask beat ", describe(got)});
            return;
         end
         want = expected_masks.pop_front();
         if (got.and_mask_byte !== want.and_mask_byte ||
             got.xor_mask_byte !== want.xor_mask_byte ||
             got.dest_row !== want.dest_row || got.dest_byte !== want.dest_byte ||
             got.hot_x !== want.hot_x || got.hot_y !== want.hot_y ||
             got.image_done !== want.image_done)
            complain({"expected ", describe(want), " got ", describe(got)});
      endfunction

      function int pending();
         return expected_masks.size();
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mask_scoreboard sb = new();
   bit             tx_burst     = 1'b0;
   bit             rx_burst     = 1'b0;
   bit             hold_request = 1'b0;
   int unsigned    quiet_cycles = 0;

   palette_icon_to_cursor_masks #(
      .ICON_SIDE  (ICON_SIDE),
      .LEVEL_STEP (LEVEL_STEP)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // Predict on every accepted pixel beat, check every accepted mask beat
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_pixels(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_masks(rsp_data);
   end

   // Give up after a long stretch with no beat moving on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: stall randomly before each beat unless in burst mode; a hold request stalls for LONG_HOLD instead
   initial begin
      int hold;
      wait (!reset);
      forever begin
         hold = rx_burst ? 0 : $urandom_range(0, 5);
         if (hold_request) begin
            hold = LONG_HOLD;
            hold_request = 1'b0;
         end
         repeat (hold) @(negedge clock) rsp_stall <= 1'b1;
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic csr_write(input int idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * idx);
      pwdata  <= value;
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input int idx, output logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(4 * idx);
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      value = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write all six registers, some with junk above the field, then read them back
   task automatic load_palette(input int bg, input int ws, input int sc,
                               input int yc, input int bc, input int rc,
                               input bit stray_writes);
      int                    vals [6];
      int                    width;
      logic [CSR_DATA_W-1:0] junk;
      logic [CSR_DATA_W-1:0] got;
      vals = '{bg, ws, sc, yc, bc, rc};
      for (int i = 0; i < 6; i++) begin
         width = (i == REG_STANDARD_COLORS) ? 9 : 8;
         junk  = $urandom_range(0, 1) ? (CSR_DATA_W'($urandom()) << width) : '0;
         csr_write(i, CSR_DATA_W'(vals[i]) | junk);
      end
      // addresses past the register list must not disturb anything
      if (stray_writes) begin
         csr_write(REG_RESERVED_COLORS + 1, CSR_DATA_W'($urandom()));
         csr_write(REG_RESERVED_COLORS + 2, CSR_DATA_W'($urandom()));
      end
      for (int i = 0; i < 6; i++) begin
         csr_read(i, got);
         if (got !== sb.read_reg(i))
            sb.complain($sformatf("register %0d read %0h, expected %0h",
                                  i, got, sb.read_reg(i)));
      end
   endtask

   task automatic send_beat(input req_type beat);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 5);
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   // Aim most pixels near the current class boundaries
   function automatic logic [7:0] pick_pixel();
      int off;
      int v;
      off = int'($urandom_range(0, 4)) - 2;
      case ($urandom_range(0, 11))
         0:       v = int'(sb.cfg.background_color);
         1:       v = int'(sb.cfg.white_start) + off;
         2:       v = int'(sb.cfg.standard_colors) - LEVEL_STEP + off;
         3:       v = int'(sb.cfg.yellow_center) - LEVEL_STEP + off;
         4:       v = int'(sb.cfg.yellow_center) + LEVEL_STEP + off;
         5:       v = int'(sb.cfg.blue_center) - LEVEL_STEP + off;
         6:       v = int'(sb.cfg.reserved_colors) + off - int'($urandom_range(0, 20));
         default: v = int'($urandom_range(0, 255));
      endcase
      return v[7:0];
   endfunction

   task automatic send_random(input int count);
      req_type beat;
      for (int n = 0; n < count; n++) begin
         beat = {pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel(),
                 pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel()};
         send_beat(beat);
      end
   endtask

   // Drop valid and wait for every outstanding mask beat
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic pick_pacing();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset palette: background, black, hot invert, level shades, blue
      pick_pacing();
      send_beat({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_beat({8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
      send_beat({8'd0, 8'd255, 8'd240, 8'd80, 8'd112, 8'd113, 8'd144, 8'd5});
      send_beat({8'd79, 8'd81, 8'd159, 8'd143, 8'd16, 8'd17, 8'd23, 8'd24});
      send_beat({8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa});
      send_beat({8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80});
      send_beat({8'hfe, 8'hfd, 8'hfb, 8'hf7, 8'hef, 8'hdf, 8'hbf, 8'h7f});
      send_random(RANDOM_BEATS);
      settle();

      // Everything at zero
      load_palette(0, 0, 0, 0, 0, 0, 1'b1);
      pick_pacing();
      send_random(RANDOM_BEATS);
      settle();

      // Everything at its maximum
      load_palette(255, 255, 256, 255, 255, 255, 1'b0);
      pick_pacing();
      send_random(RANDOM_BEATS);
      settle();

      // Wide level band with pixels below the level offset, white group with XOR
      load_palette(3, 200, 256, 0, 255, 180, 1'b0);
      pick_pacing();
      send_beat({8'd3, 8'd200, 8'd239, 8'd240, 8'd17, 8'd179, 8'd180, 8'd199});
      send_beat({8'd0, 8'd1, 8'd8, 8'd9, 8'd100, 8'd171, 8'd172, 8'd188});
      send_beat({8'd16, 8'd15, 8'd164, 8'd196, 8'd255, 8'd250, 8'd2, 8'd3});
      send_random(RANDOM_BEATS);
      settle();

      // Thresholds out of order
      load_palette(128, 100, 130, 200, 50, 7, 1'b1);
      pick_pacing();
      send_random(RANDOM_BEATS);
      settle();

      // Random palette, receiver holds off while the sender streams
      load_palette($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 256),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   1'b0);
      tx_burst     = 1'b1;
      rx_burst     = 1'b0;
      hold_request = 1'b1;
      send_random(RANDOM_BEATS);
      settle();

      // Another random palette
      load_palette($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 256),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   1'b1);
      pick_pacing();
      send_random(RANDOM_BEATS);
      settle();

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/pic2cm_pkg.sv
src/pic2cm_classify.sv
src/palette_icon_to_cursor_masks.sv
src/pic2cm_checker.sv
tb/palette_icon_to_cursor_masks_tb.sv
